>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define HFV_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hfv assertion failed");

// clocked property, checked during reset as well
`define HFV_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hfv assertion failed");

`endif

>>> src/hfv_pkg.sv
package hfv_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_NAME  = 2'd0,
      OP_VALUE = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // verdict codes
   typedef enum logic [2:0] {
      VERDICT_OK         = 3'd0,
      VERDICT_NAME_CHAR  = 3'd1,
      VERDICT_VALUE_CHAR = 3'd2,
      VERDICT_EDGE_SPACE = 3'd3,
      VERDICT_CONN_NAME  = 3'd4,
      VERDICT_TE_VALUE   = 3'd5
   } verdict_type;

   // classified request between front and back
   typedef struct packed {
      op_type     op;
      logic [7:0] lc;
      logic       upper;
      logic       name_bad;
      logic       colon;
      logic       value_bad;
      logic       space;
   } item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int NAME_LIST_SIZE = 8;
   localparam int TE_LIST_BIT    = 4;

   localparam logic [4:0] NAME_COUNT_MAX  = 5'd31;
   localparam logic [3:0] VALUE_COUNT_MAX = 4'd15;
   localparam logic [3:0] TRAILERS_LEN    = 4'd8;
   localparam logic [4:0] TE_LEN          = 5'd2;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HTAB  = 8'h09;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UP_LO = 8'h41;
   localparam logic [7:0] CHAR_UP_HI = 8'h5A;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CASE_FOLD  = 8'h20;

   // connection-specific names, right-aligned with the first character in the highest used byte
   localparam logic [151:0] NAME_CONNECTION  = 152'("connection");
   localparam logic [151:0] NAME_KEEP_ALIVE  = 152'("keep-alive");
   localparam logic [151:0] NAME_PROXY_AUTHN = 152'("proxy-authenticate");
   localparam logic [151:0] NAME_PROXY_AUTHZ = 152'("proxy-authorization");
   localparam logic [151:0] NAME_TE          = 152'("te");
   localparam logic [151:0] NAME_TRAILERS    = 152'("trailers");
   localparam logic [151:0] NAME_XFER_ENC    = 152'("transfer-encoding");
   localparam logic [151:0] NAME_UPGRADE     = 152'("upgrade");
   localparam logic [63:0]  WORD_TRAILERS    = 64'("trailers");
   localparam logic [15:0]  WORD_TE          = 16'("te");

   // length of a listed name
   function automatic logic [4:0] conn_len(input logic [2:0] idx);
      logic [4:0] l;
      case (idx)
         3'd0:    l = 5'd10;
         3'd1:    l = 5'd10;
         3'd2:    l = 5'd18;
         3'd3:    l = 5'd19;
         3'd4:    l = 5'd2;
         3'd5:    l = 5'd8;
         3'd6:    l = 5'd17;
         3'd7:    l = 5'd7;
         default: l = 5'd0;
      endcase
      return l;
   endfunction

   // character of a listed name, valid for pos below its length
   function automatic logic [7:0] conn_char(input logic [2:0] idx, input logic [4:0] pos);
      logic [151:0] s;
      logic [151:0] t;
      logic [4:0]   sh;
      case (idx)
         3'd0:    s = NAME_CONNECTION;
         3'd1:    s = NAME_KEEP_ALIVE;
         3'd2:    s = NAME_PROXY_AUTHN;
         3'd3:    s = NAME_PROXY_AUTHZ;
         3'd4:    s = NAME_TE;
         3'd5:    s = NAME_TRAILERS;
         3'd6:    s = NAME_XFER_ENC;
         3'd7:    s = NAME_UPGRADE;
         default: s = '0;
      endcase
      sh = conn_len(idx) - 5'd1 - pos;
      t  = s >> {sh, 3'b000};
      return t[7:0];
   endfunction

   // character of "trailers"
   function automatic logic [7:0] trailers_char(input logic [2:0] pos);
      logic [63:0] t;
      logic [2:0]  sh;
      sh = 3'd7 - pos;
      t  = WORD_TRAILERS >> {sh, 3'b000};
      return t[7:0];
   endfunction

   // character of "te"
   function automatic logic [7:0] te_char(input logic pos);
      return pos ? WORD_TE[7:0] : WORD_TE[15:8];
   endfunction

endpackage

>>> src/hfv_front.sv
module hfv_front (
   input  logic                req_push,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_data_byte,
   output logic                req_full,
   input  logic                queue_full,
   output logic                queue_push,
   output hfv_pkg::item_type   queue_item
);

   logic upper;

   // backpressure comes straight from the queue
   assign req_full = queue_full;

   // unused op codes are taken and dropped
   assign queue_push = req_push && !queue_full &&
                       (hfv_pkg::op_type'(req_op) != hfv_pkg::OP_NONE);

   // byte classification
   assign upper = (req_data_byte >= hfv_pkg::CHAR_UP_LO) &&
                  (req_data_byte <= hfv_pkg::CHAR_UP_HI);

   always_comb begin
      queue_item.op        = hfv_pkg::op_type'(req_op);
      queue_item.upper     = upper;
      queue_item.lc        = upper ? (req_data_byte + hfv_pkg::CASE_FOLD) : req_data_byte;
      queue_item.name_bad  = (req_data_byte <= hfv_pkg::CHAR_SPACE) || upper ||
                             (req_data_byte >= hfv_pkg::CHAR_DEL);
      queue_item.colon     = (req_data_byte == hfv_pkg::CHAR_COLON);
      queue_item.value_bad = (req_data_byte == hfv_pkg::CHAR_NUL) ||
                             (req_data_byte == hfv_pkg::CHAR_CR) ||
                             (req_data_byte == hfv_pkg::CHAR_LF);
      queue_item.space     = (req_data_byte == hfv_pkg::CHAR_SPACE) ||
                             (req_data_byte == hfv_pkg::CHAR_HTAB);
   end

endmodule

>>> src/hfv_queue.sv
module hfv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hfv_pkg::item_type   push_item,
   output logic                full,
   input  logic                pop,
   output hfv_pkg::item_type   head_item,
   output logic                empty
);

   hfv_pkg::item_type                mem_ff [hfv_pkg::QUEUE_DEPTH];
   logic [hfv_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hfv_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hfv_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                             do_push, do_pop;

   assign full      = (count_ff == hfv_pkg::QUEUE_CNT_W'(hfv_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/hfv_back.sv
module hfv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  hfv_pkg::item_type   queue_item,
   output logic                queue_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [2:0]          rsp_verdict
);

   logic [4:0]                        name_count_ff, name_count_in;
   logic [3:0]                        value_count_ff, value_count_in;
   logic                              name_bad_ff, name_bad_in;
   logic                              value_bad_ff, value_bad_in;
   logic                              first_space_ff, first_space_in;
   logic                              last_space_ff, last_space_in;
   logic [hfv_pkg::NAME_LIST_SIZE-1:0] list_match_ff, list_match_in;
   logic                              te_match_ff, te_match_in;
   logic                              trailers_match_ff, trailers_match_in;

   hfv_pkg::verdict_type              verdict;
   logic                              conn_hit;
   logic                              trailers_ok;
   logic                              take_name, take_value, take_end;

   // result queue, two entries
   hfv_pkg::verdict_type              out_mem_ff [2];
   logic                              out_wr_ff, out_rd_ff;
   logic [1:0]                        out_count_ff, out_count_in;
   logic                              out_full, out_push, out_pop;

   assign out_full    = (out_count_ff == 2'd2);
   assign rsp_empty   = (out_count_ff == 2'd0);
   assign rsp_verdict = out_mem_ff[out_rd_ff];
   assign out_pop     = rsp_pop && !rsp_empty;

   // an end request waits for room in the result queue
   assign queue_pop  = !queue_empty && ((queue_item.op != hfv_pkg::OP_END) || !out_full);
   assign take_name  = queue_pop && (queue_item.op == hfv_pkg::OP_NAME);
   assign take_value = queue_pop && (queue_item.op == hfv_pkg::OP_VALUE);
   assign take_end   = queue_pop && (queue_item.op == hfv_pkg::OP_END);
   assign out_push   = take_end;

   // verdict from the state built so far
   always_comb begin
      conn_hit = 1'b0;
      for (int i = 0; i < hfv_pkg::NAME_LIST_SIZE; i++) begin
         if (i != hfv_pkg::TE_LIST_BIT && list_match_ff[i] &&
             name_count_ff == hfv_pkg::conn_len(3'(i))) begin
            conn_hit = 1'b1;
         end
      end
      trailers_ok = trailers_match_ff && (value_count_ff == hfv_pkg::TRAILERS_LEN);
      if (name_bad_ff) begin
         verdict = hfv_pkg::VERDICT_NAME_CHAR;
      end else if (value_bad_ff) begin
         verdict = hfv_pkg::VERDICT_VALUE_CHAR;
      end else if (value_count_ff != '0 && (first_space_ff || last_space_ff)) begin
         verdict = hfv_pkg::VERDICT_EDGE_SPACE;
      end else if (conn_hit) begin
         verdict = hfv_pkg::VERDICT_CONN_NAME;
      end else if (te_match_ff && name_count_ff == hfv_pkg::TE_LEN &&
                   value_count_ff != '0 && !trailers_ok) begin
         verdict = hfv_pkg::VERDICT_TE_VALUE;
      end else begin
         verdict = hfv_pkg::VERDICT_OK;
      end
   end

   // field state update
   always_comb begin
      name_count_in     = name_count_ff;
      value_count_in    = value_count_ff;
      name_bad_in       = name_bad_ff;
      value_bad_in      = value_bad_ff;
      first_space_in    = first_space_ff;
      last_space_in     = last_space_ff;
      list_match_in     = list_match_ff;
      te_match_in       = te_match_ff;
      trailers_match_in = trailers_match_ff;
      if (take_end) begin
         name_count_in     = '0;
         value_count_in    = '0;
         name_bad_in       = 1'b0;
         value_bad_in      = 1'b0;
         first_space_in    = 1'b0;
         last_space_in     = 1'b0;
         list_match_in     = '1;
         te_match_in       = 1'b1;
         trailers_match_in = 1'b1;
      end else if (take_name) begin
         if (queue_item.name_bad || (queue_item.colon && name_count_ff != '0)) begin
            name_bad_in = 1'b1;
         end
         for (int i = 0; i < hfv_pkg::NAME_LIST_SIZE; i++) begin
            if (!(name_count_ff < hfv_pkg::conn_len(3'(i)) &&
                  queue_item.lc == hfv_pkg::conn_char(3'(i), name_count_ff))) begin
               list_match_in[i] = 1'b0;
            end
         end
         if (!(name_count_ff < hfv_pkg::TE_LEN && !queue_item.upper &&
               queue_item.lc == hfv_pkg::te_char(name_count_ff[0]))) begin
            te_match_in = 1'b0;
         end
         if (name_count_ff != hfv_pkg::NAME_COUNT_MAX) begin
            name_count_in = name_count_ff + 1'b1;
         end
      end else if (take_value) begin
         if (queue_item.value_bad) begin
            value_bad_in = 1'b1;
         end
         if (value_count_ff == '0) begin
            first_space_in = queue_item.space;
         end
         last_space_in = queue_item.space;
         if (!(value_count_ff < hfv_pkg::TRAILERS_LEN && !queue_item.upper &&
               queue_item.lc == hfv_pkg::trailers_char(value_count_ff[2:0]))) begin
            trailers_match_in = 1'b0;
         end
         if (value_count_ff != hfv_pkg::VALUE_COUNT_MAX) begin
            value_count_in = value_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff     <= '0;
         value_count_ff    <= '0;
         name_bad_ff       <= 1'b0;
         value_bad_ff      <= 1'b0;
         first_space_ff    <= 1'b0;
         last_space_ff     <= 1'b0;
         list_match_ff     <= '1;
         te_match_ff       <= 1'b1;
         trailers_match_ff <= 1'b1;
      end else begin
         name_count_ff     <= name_count_in;
         value_count_ff    <= value_count_in;
         name_bad_ff       <= name_bad_in;
         value_bad_ff      <= value_bad_in;
         first_space_ff    <= first_space_in;
         last_space_ff     <= last_space_in;
         list_match_ff     <= list_match_in;
         te_match_ff       <= te_match_in;
         trailers_match_ff <= trailers_match_in;
      end
   end

   // result queue control
   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_ff ^ out_push;
         out_rd_ff    <= out_rd_ff ^ out_pop;
         out_count_ff <= out_count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= verdict;
      end
   end

endmodule

>>> src/http2_header_field_validator.sv
// Validates one decoded HTTP/2 header field streamed a byte per request: name bytes
// (op 0), value bytes (op 1), then an end request (op 2) that yields one verdict and
// clears the field state; op 3 is taken and ignored. The block takes one request every
// cycle while req_full is low. A front stage classifies each byte and writes it into a
// four-entry queue; the back stage applies one request per cycle to the field state and
// writes verdicts into a two-entry result queue, holding an end request while that is
// full, so a stalled result side backs up the request side only once both queues fill.
// An end request is stored in the request queue, and its verdict in the result queue.
module http2_header_field_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_verdict
);

   hfv_pkg::item_type front_item, head_item;
   logic              queue_push, queue_full, queue_pop, queue_empty;

   // byte classification
   hfv_front u_front (
      .req_push      (req_push),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_item    (front_item)
   );

   // decoupling queue
   hfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_item (head_item),
      .empty     (queue_empty)
   );

   // field state and verdicts
   hfv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (head_item),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_verdict (rsp_verdict)
   );

endmodule

>>> src/hfv_checker.sv
`include "assert_macros.svh"

module hfv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [2:0] rsp_verdict
);

   // a shown verdict is one of the defined codes
   `HFV_ASSERT(a_verdict_code, clock, reset, !rsp_empty |-> rsp_verdict <= hfv_pkg::VERDICT_TE_VALUE)

   // a waiting result holds until popped
   `HFV_ASSERT(a_result_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_verdict)))

   // reset leaves both queues empty
   `HFV_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (rsp_empty && !req_full))

   // the request side only backs up behind a waiting result
   `HFV_ASSERT(a_full_needs_result, clock, reset, req_full |-> !rsp_empty)

endmodule

bind http2_header_field_validator hfv_checker u_hfv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_verdict (rsp_verdict)
);
